>>> design/text_console_writer_defines.svh
// Assertion macros used by the console writer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
// check gated off while reset is high
`define TCW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(name, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

>>> design/tcw_pkg.sv
// Shared widths and codes for the text console writer.
// No dependencies; used by the interfaces, the converter and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int VALUE_W  = 32;   // binary number width
   localparam int DIGIT_W  = 4;    // one BCD digit
   localparam int BCD_W    = 40;   // ten BCD digits
   localparam int COUNT_W  = 5;    // bit-step counter, 0..31
   localparam int NDIG_W   = 4;    // digit count, 1..10
   localparam int CHAR_W   = 8;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 7;
   localparam int ADDR_W   = 15;
   localparam int DATA_W   = 16;

   localparam logic [NDIG_W-1:0]  MAX_DIGITS   = 4'd10;
   localparam logic [COUNT_W-1:0] LAST_STEP    = 5'd31;
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 8'h30;

   // opcode field values
   localparam logic OP_CHAR   = 1'b0;
   localparam logic OP_NUMBER = 1'b1;

endpackage

>>> design/tcw_req_if.sv
// Request channel: valid/ready handshake with one character or number word.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::CHAR_W-1:0]    colour;
   logic [tcw_pkg::VALUE_W-1:0]   number_value;

   modport source (output valid, opcode, char_code, colour, number_value, input ready);
   modport sink   (input valid, opcode, char_code, colour, number_value, output ready);
endinterface

>>> design/tcw_rsp_if.sv
// Response channel: valid/ready handshake carrying one cell write word.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ADDR_W-1:0]    cell_address;
   logic [tcw_pkg::DATA_W-1:0]    cell_data;
   logic                          last;

   modport source (output valid, cell_address, cell_data, last, input ready);
   modport sink   (input valid, cell_address, cell_data, last, output ready);
endinterface

>>> design/tcw_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on tcw_pkg for widths and the step count.
`timescale 1ns / 1ps

module tcw_bcd (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tcw_pkg::VALUE_W-1:0]  value,
   output logic                         done,
   output logic [tcw_pkg::BCD_W-1:0]    digits
);

   logic [tcw_pkg::VALUE_W-1:0] bin_ff,   bin_in;
   logic [tcw_pkg::BCD_W-1:0]   bcd_ff,   bcd_in;
   logic [tcw_pkg::BCD_W-1:0]   bcd_adj;
   logic [tcw_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        busy_ff,  busy_in;
   logic                        done_ff,  done_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < tcw_pkg::BCD_W / tcw_pkg::DIGIT_W; i++) begin
         if (bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] >= 4'd5) begin
            bcd_adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] =
               bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] =
               bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W];
         end
      end
   end

   // step control
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {bcd_adj[tcw_pkg::BCD_W-2:0], bin_ff[tcw_pkg::VALUE_W-1]};
         bin_in   = {bin_ff[tcw_pkg::VALUE_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == tcw_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

>>> design/text_console_writer.sv
// Text console writer: a character word is in the output register in the cycle after
// acceptance (a newline only moves the cursor); a number word takes 32 serial BCD steps,
// then a load of the digits, then the trim state drops leading zeros one by one, then
// one cell write is registered per digit, and output stalls can hold each of those writes.
// One request is in flight at a time; a response waits in the output register.
// Synchronous active-high reset clears the cursor, the FSM and output valid.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module text_console_writer #(
   parameter int SCREEN_COLUMNS = 80
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

   localparam logic [tcw_pkg::COL_W-1:0]  COLUMNS   = tcw_pkg::COL_W'(SCREEN_COLUMNS);
   localparam logic [tcw_pkg::ADDR_W-1:0] COLUMNS_A = tcw_pkg::ADDR_W'(SCREEN_COLUMNS);

   state_type                    state_ff,   state_in;
   logic [tcw_pkg::ROW_W-1:0]    row_ff,     row_in;
   logic [tcw_pkg::COL_W-1:0]    col_ff,     col_in;
   logic [tcw_pkg::CHAR_W-1:0]   colour_ff,  colour_in;
   logic [tcw_pkg::BCD_W-1:0]    digits_ff,  digits_in;
   logic [tcw_pkg::NDIG_W-1:0]   ndig_ff,    ndig_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::ADDR_W-1:0]   rsp_addr_ff,  rsp_addr_in;
   logic [tcw_pkg::DATA_W-1:0]   rsp_data_ff,  rsp_data_in;
   logic                         rsp_last_ff,  rsp_last_in;

   logic                         slot_free;
   logic                         req_fire;
   logic                         bcd_start;
   logic                         bcd_done;
   logic [tcw_pkg::BCD_W-1:0]    bcd_digits;
   logic [tcw_pkg::COL_W-1:0]    col_next;
   logic [tcw_pkg::ROW_W-1:0]    row_next;
   logic [tcw_pkg::COL_W-1:0]    col_plus;
   logic [tcw_pkg::ADDR_W-1:0]   cur_addr;
   logic [tcw_pkg::DIGIT_W-1:0]  top_digit;

   tcw_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (req_ch.number_value),
      .done   (bcd_done),
      .digits (bcd_digits)
   );

   // handshake
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // cursor after one cell write, and the cell address at the cursor
   assign col_plus  = col_ff + 1'b1;
   assign col_next  = (col_plus == COLUMNS) ? '0 : col_plus;
   assign row_next  = (col_plus == COLUMNS) ? row_ff + 1'b1 : row_ff;
   assign cur_addr  = tcw_pkg::ADDR_W'(row_ff) * COLUMNS_A + tcw_pkg::ADDR_W'(col_ff);
   assign top_digit = digits_ff[tcw_pkg::BCD_W-1 -: tcw_pkg::DIGIT_W];

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      colour_in    = colour_ff;
      digits_in    = digits_ff;
      ndig_in      = ndig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      bcd_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               colour_in = req_ch.colour;
               if (req_ch.opcode == tcw_pkg::OP_CHAR) begin
                  if (req_ch.char_code == tcw_pkg::NEWLINE_CODE) begin
                     row_in = row_ff + 1'b1;
                     col_in = '0;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_addr_in  = cur_addr;
                     rsp_data_in  = {req_ch.colour, req_ch.char_code};
                     rsp_last_in  = 1'b1;
                     row_in       = row_next;
                     col_in       = col_next;
                  end
               end else begin
                  bcd_start = 1'b1;
                  state_in  = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            if (bcd_done) begin
               digits_in = bcd_digits;
               ndig_in   = tcw_pkg::MAX_DIGITS;
               state_in  = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && ndig_ff != 4'd1) begin
               digits_in = {digits_ff[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0],
                            {tcw_pkg::DIGIT_W{1'b0}}};
               ndig_in   = ndig_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = cur_addr;
               rsp_data_in  = {colour_ff, tcw_pkg::ASCII_ZERO | tcw_pkg::CHAR_W'(top_digit)};
               rsp_last_in  = (ndig_ff == 4'd1);
               row_in       = row_next;
               col_in       = col_next;
               digits_in    = {digits_ff[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0],
                               {tcw_pkg::DIGIT_W{1'b0}}};
               ndig_in      = ndig_ff - 1'b1;
               if (ndig_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      colour_ff   <= colour_in;
      digits_ff   <= digits_in;
      ndig_ff     <= ndig_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.cell_address = rsp_addr_ff;
   assign rsp_ch.cell_data    = rsp_data_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // checks
   `TCW_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid_ff && state_ff == ST_IDLE, "reset did not clear output or FSM")
   `TCW_ASSERT(a_col_range, clock, reset, col_ff < COLUMNS, "cursor column out of range")
   `TCW_ASSERT(a_done_in_convert, clock, reset, bcd_done |-> state_ff == ST_CONVERT, "converter finished outside conversion")
   `TCW_ASSERT(a_emit_count, clock, reset, state_ff == ST_EMIT |-> ndig_ff != 4'd0 && ndig_ff <= tcw_pkg::MAX_DIGITS, "digit count out of range while emitting")
   `TCW_ASSERT(a_emit_digit, clock, reset, state_ff == ST_EMIT |-> top_digit <= 4'd9, "non-decimal digit emitted")

endmodule

>>> tb/text_console_writer_tb.sv
// Self-checking bench for text_console_writer: character, newline and number words
// are checked against an in-bench cursor and decimal predictor.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;

   localparam int COLUMNS     = 80;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int DRAIN_WAIT  = 64;    // longer than the slowest number word
   localparam int HOLD_LEN    = 300;
   localparam int PHASE_WORDS = 25;

   typedef struct {
      logic [tcw_pkg::ADDR_W-1:0] addr;
      logic [tcw_pkg::DATA_W-1:0] data;
      logic                       last;
   } cell_type;

   // Cursor and decimal predictor plus the queue of cell writes still due
   class cell_scoreboard;
      cell_type                   cells_due[$];
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
      int                         errors;
      int                         checked;
      int                         chars;
      int                         newlines;
      int                         numbers;

      function new();
         row = '0;
         col = '0;
      endfunction

      function int pending();
         return cells_due.size();
      endfunction

      // one cell at the cursor, then step the cursor with column wrap
      function void put_cell(logic [tcw_pkg::CHAR_W-1:0] ch,
                             logic [tcw_pkg::CHAR_W-1:0] attr, logic last);
         cell_type c;
         c.addr = tcw_pkg::ADDR_W'(int'(row) * COLUMNS + int'(col));
         c.data = {attr, ch};
         c.last = last;
         cells_due.push_back(c);
         if (int'(col) + 1 >= COLUMNS) begin
            col = '0;
            row = row + 1'b1;
         end else begin
            col = col + 1'b1;
         end
      endfunction

      // accepted input word
      function void note_word(logic op, logic [tcw_pkg::CHAR_W-1:0] ch,
                              logic [tcw_pkg::CHAR_W-1:0] attr,
                              logic [tcw_pkg::VALUE_W-1:0] num);
         logic [tcw_pkg::DIGIT_W-1:0] digits[10];
         int                          ndig;
         if (op == tcw_pkg::OP_CHAR) begin
            if (ch == tcw_pkg::NEWLINE_CODE) begin
               newlines++;
               row = row + 1'b1;
               col = '0;
            end else begin
               chars++;
               put_cell(ch, attr, 1'b1);
            end
         end else begin
            numbers++;
            // least significant digit first, no leading zeros, zero gives "0"
            ndig = 0;
            do begin
               digits[ndig] = 4'(num % 10);
               ndig++;
               num = num / 10;
            end while (num != 0 && ndig < 10);
            for (int i = ndig - 1; i >= 0; i--)
               put_cell(tcw_pkg::ASCII_ZERO + tcw_pkg::CHAR_W'(digits[i]), attr, i == 0);
         end
      endfunction

      // accepted cell write against the oldest one due
      function void check_word(logic [tcw_pkg::ADDR_W-1:0] addr,
                               logic [tcw_pkg::DATA_W-1:0] data, logic last);
         cell_type want;
         if (cells_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected cell write addr %0d data %h last %b",
                     $time, addr, data, last);
            return;
         end
         want = cells_due.pop_front();
         checked++;
         if (addr !== want.addr) begin
            errors++;
            $display("%0t: cell_address expected %0d got %0d", $time, want.addr, addr);
         end
         if (data !== want.data) begin
            errors++;
            $display("%0t: cell_data expected %h got %h", $time, want.data, data);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %b got %b", $time, want.last, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_cycles;

   cell_scoreboard sb = new();

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   text_console_writer #(.SCREEN_COLUMNS(COLUMNS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d cell writes still due", $time, sb.pending());
         $display("text_console_writer test failed");
         $finish;
      end
   end

   // receiver: check accepted words, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word(rsp_if.cell_address, rsp_if.cell_data, rsp_if.last);
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // offer one word, with random gaps before it; returns at the accepting edge
   task automatic send_word(logic op, logic [tcw_pkg::CHAR_W-1:0] ch,
                            logic [tcw_pkg::CHAR_W-1:0] attr,
                            logic [tcw_pkg::VALUE_W-1:0] num);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.char_code    <= ch;
      req_if.colour       <= attr;
      req_if.number_value <= num;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(op, ch, attr, num);
   endtask

   // sender stops until every due cell write has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // random word: characters of any byte value (some newlines) or numbers, mostly short, some extremes
   task automatic send_random();
      logic                        op;
      logic [tcw_pkg::CHAR_W-1:0]  ch;
      logic [tcw_pkg::VALUE_W-1:0] num;
      int unsigned                 span;
      op = 1'($urandom_range(1));
      ch = ($urandom_range(99) < 15) ? tcw_pkg::NEWLINE_CODE
                                     : tcw_pkg::CHAR_W'($urandom_range(255));
      case ($urandom_range(4))
         0: num = $urandom;
         1: begin
            span = 1;
            repeat ($urandom_range(1, 9)) span = span * 10;
            num = $urandom % span;
         end
         2: num = $urandom_range(99);
         3: num = $urandom_range(9);
         default: begin
            case ($urandom_range(3))
               0: num = '0;
               1: num = '1;
               2: num = 32'd999_999_999;
               default: num = 32'd1_000_000_000;
            endcase
         end
      endcase
      send_word(op, ch, tcw_pkg::CHAR_W'($urandom_range(255)), num);
   endtask

   // main sequence
   initial begin
      reset                = 1'b1;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      hold_cycles          = 0;
      req_if.valid         = 1'b0;
      req_if.opcode        = tcw_pkg::OP_CHAR;
      req_if.char_code     = '0;
      req_if.colour        = '0;
      req_if.number_value  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: byte and attribute extremes, newline, number extremes
      send_word(tcw_pkg::OP_CHAR,   8'h00, 8'h00, 32'h0);
      send_word(tcw_pkg::OP_CHAR,   8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_word(tcw_pkg::OP_CHAR,   8'h80, 8'h01, 32'h0);
      send_word(tcw_pkg::OP_CHAR,   8'h7F, 8'h80, 32'h1234_5678);
      send_word(tcw_pkg::OP_CHAR,   tcw_pkg::NEWLINE_CODE, 8'hAA, 32'h0);
      send_word(tcw_pkg::OP_NUMBER, 8'h00, 8'h07, 32'd0);
      send_word(tcw_pkg::OP_NUMBER, 8'h00, 8'h1F, 32'hFFFF_FFFF);
      send_word(tcw_pkg::OP_NUMBER, 8'hFF, 8'h20, 32'd9);
      send_word(tcw_pkg::OP_NUMBER, 8'h0A, 8'h21, 32'd10);
      send_word(tcw_pkg::OP_NUMBER, 8'h00, 8'h22, 32'd1_000_000_000);
      send_word(tcw_pkg::OP_NUMBER, 8'h55, 8'hC3, 32'd123_456_789);
      send_word(tcw_pkg::OP_NUMBER, 8'hAA, 8'h3C, 32'hAAAA_AAAA);
      send_word(tcw_pkg::OP_NUMBER, 8'h55, 8'h5A, 32'h5555_5555);
      send_word(tcw_pkg::OP_CHAR,   8'h09, 8'hA5, 32'hAAAA_AAAA);
      send_word(tcw_pkg::OP_CHAR,   8'h0B, 8'h5A, 32'h5555_5555);
      send_word(tcw_pkg::OP_CHAR,   tcw_pkg::NEWLINE_CODE, 8'h00, 32'h0);
      send_word(tcw_pkg::OP_CHAR,   tcw_pkg::NEWLINE_CODE, 8'hFF, 32'hFFFF_FFFF);
      send_word(tcw_pkg::OP_CHAR,   8'h41, 8'h0F, 32'h0);
      send_word(tcw_pkg::OP_NUMBER, 8'h30, 8'hF0, 32'd4_294_967_294);
      drain();

      // row overflow through column wrap: 80 digits on row 255 end at row 0
      do send_word(tcw_pkg::OP_CHAR, tcw_pkg::NEWLINE_CODE, 8'h00, 32'h0);
      while (sb.row != 8'd255);
      repeat (8) send_word(tcw_pkg::OP_NUMBER, 8'h00, 8'h4E, 32'hFFFF_FFFF);
      send_word(tcw_pkg::OP_CHAR, 8'h21, 8'h71, 32'h0);
      drain();

      // random phases; the first one opens with a long receiver hold-off
      hold_cycles = HOLD_LEN;
      repeat (PHASE_WORDS) send_random();
      drain();

      send_idle_pct  = 57;
      recv_stall_pct = 0;
      repeat (PHASE_WORDS) send_random();
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 57;
      repeat (PHASE_WORDS) send_random();
      drain();

      send_idle_pct  = 35;
      recv_stall_pct = 35;
      repeat (PHASE_WORDS) send_random();
      drain();

      // let any trailing work settle, then report
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d cell writes never arrived", $time, sb.pending());
      end
      $display("Sent %0d characters, %0d newlines and %0d numbers; %0d cell writes checked.",
               sb.chars, sb.newlines, sb.numbers, sb.checked);
      $display("Covered row wrap at the screen edge, receiver hold-off and four idle mixes;");
      $display("%0d errors.", sb.errors);
      if (sb.errors == 0) begin
         $display("text_console_writer test passed");
      end else begin
         $display("text_console_writer test failed");
      end
      $finish;
   end

endmodule

>>> text_console_writer.f
+incdir+design
design/tcw_pkg.sv
design/tcw_req_if.sv
design/tcw_rsp_if.sv
design/tcw_bcd.sv
design/text_console_writer.sv
tb/text_console_writer_tb.sv
